>>> rtl/core/cdtf_pkg.sv
package cdtf_pkg;

  localparam int TIME_BITS  = 48;
  localparam int COUNT_BITS = 16;

  localparam int EVENT_TIME_BITS  = 48;
  localparam int DEAD_TIME_BITS   = 32;
  localparam int BUFFER_SIZE_BITS = 16;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int CFG_DATA_BITS    = 32;

  localparam int CMP_BITS = (COUNT_BITS > BUFFER_SIZE_BITS) ? COUNT_BITS : BUFFER_SIZE_BITS;

  localparam logic [63:0] TIME_MAX_WIDE = {64{1'b1}} >> (64 - TIME_BITS);
  localparam logic [TIME_BITS-1:0]  TIME_MAX  = {TIME_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_DEAD_TIME   = 3'd0,
    CFG_PARALYSABLE = 3'd1,
    CFG_BUF_SIZE    = 3'd2,
    CFG_BUF_MODE    = 3'd3,
    CFG_CONSERVE    = 3'd4
  } cfg_reg_t;

endpackage

>>> rtl/core/cdtf_if.sv
interface cdtf_event_if
  import cdtf_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic [EVENT_TIME_BITS-1:0] event_time_ps;
  logic                       first_of_event;
  logic                       is_pair;

  modport source (output valid, event_time_ps, first_of_event, is_pair, input ready);
  modport sink   (input valid, event_time_ps, first_of_event, is_pair, output ready);
endinterface

interface cdtf_verdict_if;
  logic valid;
  logic ready;
  logic keep;

  modport source (output valid, keep, input ready);
  modport sink   (input valid, keep, output ready);
endinterface

interface cdtf_cfg_if
  import cdtf_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/coincidence_dead_time_filter_top.sv
// Dead-time filter for a coincidence event stream. Every event transfer on
// the input yields exactly one verdict transfer on the output, in order, with
// keep set when the event is forwarded. An event is held in an input
// register, judged against the rebirth time and buffer count, and its verdict
// lands in an output register; one event is taken every cycle while the
// verdict side keeps up, and a stalled verdict holds the pipeline. The rebirth
// time and buffer count update in the same cycle as the judgment, which sets
// the one-event-per-cycle figure.
// Configuration writes are always taken and should be made while no event is
// in flight.
module coincidence_dead_time_filter_top
  import cdtf_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  cdtf_event_if.sink     events,
  cdtf_verdict_if.source verdicts,
  cdtf_cfg_if.sink       cfg
);

  logic [DEAD_TIME_BITS-1:0]   dead_time_ps;
  logic                        paralysable;
  logic [BUFFER_SIZE_BITS-1:0] buffer_size;
  logic                        buffer_mode;
  logic                        conserve_all_event;

  logic [TIME_BITS-1:0]  rebirth_time, rebirth_time_next;
  logic [COUNT_BITS-1:0] buffer_count, buffer_count_next;
  logic                  first_taken, first_taken_next;

  logic                       in_vld;
  logic [EVENT_TIME_BITS-1:0] in_time;
  logic                       in_first;
  logic                       in_pair;

  logic out_vld;
  logic out_keep;

  logic advance;
  logic fire;
  logic keep_c;

  logic [63:0]           t_wide;
  logic [TIME_BITS-1:0]  t_cl;
  logic [TIME_BITS:0]    t_sum;
  logic [TIME_BITS-1:0]  deadline;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  size_nz;
  logic                  inc_ge_size;
  logic                  inc_eq_size;
  logic                  cnt_lt_size;

  assign cfg.ready      = 1'b1;
  assign advance        = !out_vld || verdicts.ready;
  assign events.ready   = !in_vld || advance;
  assign fire           = in_vld && advance;
  assign verdicts.valid = out_vld;
  assign verdicts.keep  = out_keep;

  assign t_wide   = 64'(in_time);
  assign t_cl     = (t_wide > TIME_MAX_WIDE) ? TIME_MAX : TIME_BITS'(t_wide);
  assign t_sum    = {1'b0, t_cl} + (TIME_BITS + 1)'(dead_time_ps);
  assign deadline = t_sum[TIME_BITS] ? TIME_MAX : t_sum[TIME_BITS-1:0];

  assign count_inc   = (buffer_count == COUNT_MAX) ? buffer_count : buffer_count + 1'b1;
  assign size_nz     = (buffer_size != '0);
  assign inc_ge_size = CMP_BITS'(count_inc) >= CMP_BITS'(buffer_size);
  assign inc_eq_size = CMP_BITS'(count_inc) == CMP_BITS'(buffer_size);
  assign cnt_lt_size = CMP_BITS'(buffer_count) < CMP_BITS'(buffer_size);

  always_comb begin
    keep_c            = 1'b0;
    rebirth_time_next = rebirth_time;
    buffer_count_next = buffer_count;
    first_taken_next  = first_taken;
    if (!in_pair) begin
      keep_c = 1'b0;
    end else if (conserve_all_event && !in_first) begin
      // Follower coincidence copies the verdict given to the first one.
      keep_c = first_taken;
      if (first_taken && size_nz) begin
        buffer_count_next = count_inc;
      end
    end else begin
      if (t_cl >= rebirth_time) begin
        keep_c = 1'b1;
        if (size_nz) begin
          buffer_count_next = count_inc;
          if (inc_ge_size) begin
            rebirth_time_next = deadline;
            buffer_count_next = '0;
          end
        end else begin
          rebirth_time_next = deadline;
        end
      end else if (size_nz && buffer_mode) begin
        if (cnt_lt_size) begin
          buffer_count_next = count_inc;
          keep_c            = 1'b1;
          if (paralysable && inc_eq_size) begin
            rebirth_time_next = deadline;
          end
        end
      end else if (paralysable && !size_nz) begin
        rebirth_time_next = deadline;
      end
      if (conserve_all_event) begin
        first_taken_next = keep_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_time_ps       <= '0;
      paralysable        <= 1'b0;
      buffer_size        <= '0;
      buffer_mode        <= 1'b0;
      conserve_all_event <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_DEAD_TIME:   dead_time_ps       <= cfg.data[DEAD_TIME_BITS-1:0];
        CFG_PARALYSABLE: paralysable        <= cfg.data[0];
        CFG_BUF_SIZE:    buffer_size        <= cfg.data[BUFFER_SIZE_BITS-1:0];
        CFG_BUF_MODE:    buffer_mode        <= cfg.data[0];
        CFG_CONSERVE:    conserve_all_event <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rebirth_time <= '0;
      buffer_count <= '0;
      first_taken  <= 1'b0;
      in_vld       <= 1'b0;
      out_vld      <= 1'b0;
    end else begin
      if (fire) begin
        rebirth_time <= rebirth_time_next;
        buffer_count <= buffer_count_next;
        first_taken  <= first_taken_next;
      end
      if (events.ready) begin
        in_vld <= events.valid;
      end
      if (advance) begin
        out_vld <= in_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (events.ready && events.valid) begin
      in_time  <= events.event_time_ps;
      in_first <= events.first_of_event;
      in_pair  <= events.is_pair;
    end
    if (fire) begin
      out_keep <= keep_c;
    end
  end

endmodule

>>> rtl/core/cdtf_checker.sv
module cdtf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_keep,
  input logic cfg_ready
);

  // A held verdict keeps its value until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_keep))
    else $error("verdict changed while stalled");

  // The input only backs up when a verdict is waiting on the output.
  a_in_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // No verdict appears in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("verdict valid right after reset");

  // The configuration port never stalls.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind coincidence_dead_time_filter_top cdtf_checker u_cdtf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (events.valid),
  .in_ready  (events.ready),
  .out_valid (verdicts.valid),
  .out_ready (verdicts.ready),
  .out_keep  (verdicts.keep),
  .cfg_ready (cfg.ready)
);
